// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Depends on nothing; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define PICP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error(msg);

// Concurrent assertion that also holds during reset.
`define PICP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== design/picp_pkg.sv =====
// Package for the convex polygon membership block: fixed widths, codes and
// the status type that the orientation unit hands to the sequencer. No dependencies.
`default_nettype none

package picp_pkg;

    // Fixed field widths
    localparam int CNT_W = 9;
    localparam int IDX_W = 8;

    // Register reset value and lower clamp of the vertex count
    localparam logic [CNT_W-1:0] CNT_RESET = 9'd3;
    localparam int MIN_VERTS = 3;

    // Request function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Result of one orientation test
    typedef struct packed {
        logic done;    // status valid this cycle
        logic pos;     // point left of the directed segment
        logic zero;    // point on the line through the segment
        logic in_box;  // point within the segment's bounding box
    } t_orient_stat;

endpackage

`default_nettype wire

// ===== design/picp_orient.sv =====
// Shared orientation unit: one multiplier forms the two cross-product terms in
// turn, then a compare gives the sign. Depends on picp_pkg.
`default_nettype none

module picp_orient #(
    parameter int COORD_WIDTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire logic signed [COORD_WIDTH-1:0] i_ax,
    input  wire logic signed [COORD_WIDTH-1:0] i_ay,
    input  wire logic signed [COORD_WIDTH-1:0] i_bx,
    input  wire logic signed [COORD_WIDTH-1:0] i_by,
    input  wire logic signed [COORD_WIDTH-1:0] i_cx,
    input  wire logic signed [COORD_WIDTH-1:0] i_cy,
    output picp_pkg::t_orient_stat       o_stat
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_MUL1 = 4'b0010,
        U_MUL2 = 4'b0100,
        U_CMP  = 4'b1000
    } t_ustate;

    t_ustate r_state, n_state;

    logic signed [COORD_WIDTH-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [PW-1:0]          r_p1, r_p2;
    logic signed [DW-1:0]          dbx, dby, dcx, dcy, op_a, op_b;
    logic signed [PW-1:0]          prod;
    logic                          take;

    // Accept a new test when idle or while the last one reports
    assign take = i_start && ((r_state == U_IDLE) || (r_state == U_CMP));

    // Differences at one extra bit, so nothing wraps
    assign dbx = DW'(r_bx) - DW'(r_ax);
    assign dby = DW'(r_by) - DW'(r_ay);
    assign dcx = DW'(r_cx) - DW'(r_ax);
    assign dcy = DW'(r_cy) - DW'(r_ay);

    // Steer the single multiplier
    assign op_a = (r_state == U_MUL1) ? dbx : dby;
    assign op_b = (r_state == U_MUL1) ? dcy : dcx;
    assign prod = op_a * op_b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            U_IDLE: if (take) n_state = U_MUL1;
            U_MUL1: n_state = U_MUL2;
            U_MUL2: n_state = U_CMP;
            U_CMP:  n_state = take ? U_MUL1 : U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch operands and products
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ax <= i_ax;
            r_ay <= i_ay;
            r_bx <= i_bx;
            r_by <= i_by;
            r_cx <= i_cx;
            r_cy <= i_cy;
        end
        if (r_state == U_MUL1) r_p1 <= prod;
        if (r_state == U_MUL2) r_p2 <= prod;
    end

    // Report sign and bounding-box test
    always_comb begin
        o_stat.done   = (r_state == U_CMP);
        o_stat.pos    = (r_p1 > r_p2);
        o_stat.zero   = (r_p1 == r_p2);
        o_stat.in_box = (r_cx >= ((r_ax < r_bx) ? r_ax : r_bx)) &&
                        (r_cx <= ((r_ax > r_bx) ? r_ax : r_bx)) &&
                        (r_cy >= ((r_ay < r_by) ? r_ay : r_by)) &&
                        (r_cy <= ((r_ay > r_by) ? r_ay : r_by));
    end

endmodule

`default_nettype wire

// ===== design/point_in_convex_polygon_core.sv =====
// Top level of the convex polygon membership block: vertex memory, count
// register, search sequencer and output register. Depends on picp_pkg, picp_orient.
//
// Use: write vertex_count on the cfg channel (always ready) while idle, load
// vertices counterclockwise with func=load requests, then send func=query
// requests. A load writes one table slot in the accept cycle, gives no result
// and leaves the block free the next cycle. A query returns one inside_res.
// A query halves the vertex fan at most ceil(log2(n-1)) times, for n vertices;
// a point on a tested line ends early. Query time is set by the single
// multiplier, which forms two products per orientation test, and by the
// single memory read port. o_in_stall stays high for the whole query. The
// result sits in an output register; while the receiver stalls it holds, and
// a following load is still accepted. A finished query waits in place until
// that register is free. Synchronous reset clears control state and sets
// vertex_count to 3; table contents are undefined until written.
`default_nettype none

module point_in_convex_polygon_core #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_WIDTH  = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Request channel
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_func,
    input  wire logic [picp_pkg::IDX_W-1:0]     i_vertex_index,
    input  wire logic signed [COORD_WIDTH-1:0]  i_point_x,
    input  wire logic signed [COORD_WIDTH-1:0]  i_point_y,
    // Result channel
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic                                o_inside_res,
    // Configuration channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [picp_pkg::CNT_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int VW = 2 * COORD_WIDTH;
    localparam int NW = (picp_pkg::CNT_W > AW + 1) ? picp_pkg::CNT_W : AW + 1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_V0     = 10'b00_0000_0010,
        S_SEARCH = 10'b00_0000_0100,
        S_MIDW   = 10'b00_0000_1000,
        S_MIDO   = 10'b00_0001_0000,
        S_HIGH   = 10'b00_0010_0000,
        S_T1     = 10'b00_0100_0000,
        S_T2     = 10'b00_1000_0000,
        S_T3     = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [picp_pkg::CNT_W-1:0] r_vcount;
    logic [VW-1:0]              r_mem [MAX_VERTICES];
    logic [VW-1:0]              r_rd, r_v0, r_vlo;
    logic signed [COORD_WIDTH-1:0] r_px, r_py;
    logic [AW-1:0]              r_lo, r_hi, n_lo, n_hi;
    logic                       r_d1, r_d2, r_res, n_res;
    logic                       r_out_valid, r_out_res;

    logic                       in_acc, is_query, is_load, slot_ok;
    logic [NW-1:0]              cnt_ext, n_eff, n_last;
    logic [AW:0]                sum_lh;
    logic [AW-1:0]              mid;
    logic                       more;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       u_start;
    logic [VW-1:0]              op_a, op_b;
    picp_pkg::t_orient_stat     ost;
    logic                       out_free;

    // Handshake decode
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign is_query = in_acc && (i_func == picp_pkg::FUNC_QUERY);
    assign is_load  = in_acc && (i_func == picp_pkg::FUNC_LOAD);
    assign slot_ok  = (32'(i_vertex_index) < 32'(MAX_VERTICES));

    // Clamp the vertex count between the minimum and the table size
    assign cnt_ext = NW'(r_vcount);
    always_comb begin
        if (cnt_ext < NW'(picp_pkg::MIN_VERTS)) begin
            n_eff = NW'(picp_pkg::MIN_VERTS);
        end else if (cnt_ext > NW'(MAX_VERTICES)) begin
            n_eff = NW'(MAX_VERTICES);
        end else begin
            n_eff = cnt_ext;
        end
    end
    assign n_last = n_eff - NW'(1);

    // Search bounds
    assign sum_lh = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid    = sum_lh[AW:1];
    assign more   = (({1'b0, r_lo} + (AW + 1)'(1)) < {1'b0, r_hi});

    // Memory read port
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (r_state)
            S_IDLE: rd_en = is_query;
            S_SEARCH: begin
                rd_en   = 1'b1;
                rd_addr = more ? mid : r_lo;
            end
            S_HIGH: begin
                rd_en   = 1'b1;
                rd_addr = r_hi;
            end
            default: rd_en = 1'b0;
        endcase
    end

    // Vertex table: write on load, registered read
    always_ff @(posedge i_clk) begin
        if (is_load && slot_ok) r_mem[AW'(i_vertex_index)] <= {i_point_x, i_point_y};
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    // Pick operands for the orientation unit
    always_comb begin
        u_start = 1'b0;
        op_a    = r_v0;
        op_b    = r_rd;
        unique case (r_state)
            S_MIDW: u_start = 1'b1;
            S_HIGH: u_start = 1'b1;
            S_T1: begin
                u_start = ost.done && !ost.zero;
                op_a    = r_vlo;
                op_b    = r_rd;
            end
            S_T2: begin
                u_start = ost.done && !ost.zero;
                op_a    = r_rd;
                op_b    = r_v0;
            end
            default: u_start = 1'b0;
        endcase
    end

    picp_orient #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_orient (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (u_start),
        .i_ax    ($signed(op_a[VW-1 -: COORD_WIDTH])),
        .i_ay    ($signed(op_a[COORD_WIDTH-1:0])),
        .i_bx    ($signed(op_b[VW-1 -: COORD_WIDTH])),
        .i_by    ($signed(op_b[COORD_WIDTH-1:0])),
        .i_cx    (r_px),
        .i_cy    (r_py),
        .o_stat  (ost)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (is_query) begin
                    n_state = S_V0;
                    n_lo    = '0;
                    n_hi    = n_last[AW-1:0];
                end
            end
            S_V0:     n_state = S_SEARCH;
            S_SEARCH: n_state = more ? S_MIDW : S_HIGH;
            S_MIDW:   n_state = S_MIDO;
            S_MIDO: begin
                if (ost.done) begin
                    if (ost.zero) begin
                        n_res   = ost.in_box;
                        n_state = S_DONE;
                    end else begin
                        if (ost.pos) n_lo = mid;
                        else n_hi = mid;
                        n_state = S_SEARCH;
                    end
                end
            end
            S_HIGH: n_state = S_T1;
            S_T1: begin
                if (ost.done) begin
                    if (ost.zero) begin
                        n_res   = ost.in_box;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_T2;
                    end
                end
            end
            S_T2: begin
                if (ost.done) begin
                    if (ost.zero) begin
                        n_res   = ost.in_box;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_T3;
                    end
                end
            end
            S_T3: begin
                if (ost.done) begin
                    n_res   = ost.zero ? ost.in_box
                                       : ((r_d1 == r_d2) && (r_d1 == ost.pos));
                    n_state = S_DONE;
                end
            end
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= picp_pkg::CNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_vcount <= i_cfg_data;
            // Load the output register, or drop a taken result
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_res <= n_res;
        if (is_query) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
        end
        if (r_state == S_V0) r_v0 <= r_rd;
        if (r_state == S_HIGH) r_vlo <= r_rd;
        if (r_state == S_T1 && ost.done) r_d1 <= ost.pos;
        if (r_state == S_T2 && ost.done) r_d2 <= ost.pos;
        if (r_state == S_DONE && out_free) r_out_res <= r_res;
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_res;

endmodule

`default_nettype wire

// ===== design/picp_checker.sv =====
// Port-level checker for the convex polygon membership block, bound to the
// top level. Depends on picp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module picp_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire o_in_stall,
    input wire i_func,
    input wire o_out_valid,
    input wire i_out_stall,
    input wire o_inside_res
);

    // No result is shown right after reset
    `PICP_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // A result that is stalled stays offered
    `PICP_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid, "stalled result dropped")

    // A query request keeps the block busy
    `PICP_ASSERT(a_query_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall && i_func == picp_pkg::FUNC_QUERY) |=> o_in_stall, "query did not occupy block")

    // A load request leaves the block free
    `PICP_ASSERT(a_load_free, i_clk, i_rst_n, (i_in_valid && !o_in_stall && i_func == picp_pkg::FUNC_LOAD) |=> !o_in_stall, "load blocked requests")

    // A new result only follows a busy cycle
    `PICP_ASSERT(a_res_after_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall), "result without query")

endmodule

bind point_in_convex_polygon_core picp_checker u_picp_checker (.*);

`default_nettype wire

// ===== test/point_in_convex_polygon_core_tb.sv =====
// Testbench for point_in_convex_polygon_core: loads polygons, sends point queries and
// checks each inside/outside verdict against an in-bench predictor, with random idling.
// Depends on picp_pkg and the core RTL; needs no files or arguments.
module point_in_convex_polygon_core_tb;

    localparam int SLOTS        = 256;
    localparam int CW           = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int TAIL_CYCLES  = 100;
    localparam int LONG_HOLD    = 300;
    localparam int LOAD_SETTLE  = 4;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {ANS_OUT, ANS_IN, ANS_CALC} t_answer;

    typedef struct packed {
        t_row_kind                  kind;
        logic [picp_pkg::CNT_W-1:0] arg;   // slot for a load, count for a register write
        logic signed [CW-1:0]       x;
        logic signed [CW-1:0]       y;
        t_answer                    want;
    } t_script_row;

    typedef struct packed {
        logic        in_poly;
        logic [31:0] serial;
    } t_verdict;

    // Clock, reset and block inputs
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       func = picp_pkg::FUNC_LOAD;
    logic [picp_pkg::IDX_W-1:0] vidx = '0;
    logic signed [CW-1:0]       px = '0;
    logic signed [CW-1:0]       py = '0;
    logic                       out_stall = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [picp_pkg::CNT_W-1:0] cfg_data = '0;
    wire                        in_stall;
    wire                        out_valid;
    wire                        inside_res;
    wire                        cfg_ready;

    // Predictor state: vertex table and vertex count as the block should hold them
    longint                     poly_x [SLOTS];
    longint                     poly_y [SLOTS];
    logic [picp_pkg::CNT_W-1:0] poly_count;

    t_verdict    inside_q [$];
    t_script_row script [$];
    int          error_count = 0;
    int          sent_count = 0;
    int          query_serial = 0;
    int          send_calm = 0;
    int          cycle_count = 0;
    bit          hold_request = 1'b0;

    point_in_convex_polygon_core #(
        .MAX_VERTICES(SLOTS),
        .COORD_WIDTH (CW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_func        (func),
        .i_vertex_index(vidx),
        .i_point_x     (px),
        .i_point_y     (py),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_inside_res  (inside_res),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor: exact orientation, box test and fan search
    function automatic int turn_sign(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy);
        longint cr;
        cr = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        return (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
    endfunction

    function automatic bit in_segment_box(longint ax, longint ay, longint bx, longint by,
                                          longint cx, longint cy);
        return cx >= ((ax < bx) ? ax : bx) && cx <= ((ax > bx) ? ax : bx) &&
               cy >= ((ay < by) ? ay : by) && cy <= ((ay > by) ? ay : by);
    endfunction

    function automatic int used_vertices(logic [picp_pkg::CNT_W-1:0] cnt);
        return (cnt < picp_pkg::MIN_VERTS) ? picp_pkg::MIN_VERTS
                                           : ((cnt > SLOTS) ? SLOTS : int'(cnt));
    endfunction

    function automatic bit point_inside(longint qx, longint qy);
        int lo, hi, mid, d, d1, d2, d3;
        lo = 0;
        hi = used_vertices(poly_count) - 1;
        // Narrow the wedge of the fan from vertex 0
        while (lo + 1 < hi) begin
            mid = (lo + hi) / 2;
            d = turn_sign(poly_x[0], poly_y[0], poly_x[mid], poly_y[mid], qx, qy);
            if (d == 0)
                return in_segment_box(poly_x[0], poly_y[0], poly_x[mid], poly_y[mid], qx, qy);
            if (d > 0)
                lo = mid;
            else
                hi = mid;
        end
        // Test the three sides of the wedge triangle
        d1 = turn_sign(poly_x[0], poly_y[0], poly_x[lo], poly_y[lo], qx, qy);
        if (d1 == 0)
            return in_segment_box(poly_x[0], poly_y[0], poly_x[lo], poly_y[lo], qx, qy);
        d2 = turn_sign(poly_x[lo], poly_y[lo], poly_x[hi], poly_y[hi], qx, qy);
        if (d2 == 0)
            return in_segment_box(poly_x[lo], poly_y[lo], poly_x[hi], poly_y[hi], qx, qy);
        d3 = turn_sign(poly_x[hi], poly_y[hi], poly_x[0], poly_y[0], qx, qy);
        if (d3 == 0)
            return in_segment_box(poly_x[hi], poly_y[hi], poly_x[0], poly_y[0], qx, qy);
        return d1 == d2 && d1 == d3;
    endfunction

    function automatic longint clip_coord(longint v);
        return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
    endfunction

    function automatic longint rand_coord();
        return longint'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic longint extreme_coord();
        case ($urandom_range(0, 3))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            default: return 32767;
        endcase
    endfunction

    function automatic void note_mismatch(string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", what);
    endfunction

    task automatic script_row(t_row_kind kind, int arg, int x, int y, t_answer want);
        t_script_row row;
        row.kind = kind;
        row.arg  = arg[picp_pkg::CNT_W-1:0];
        row.x    = x[CW-1:0];
        row.y    = y[CW-1:0];
        row.want = want;
        script.push_back(row);
    endtask

    // Offer one request after a random gap; update the predictor when it is taken
    task automatic send_request(input logic f, input logic [picp_pkg::IDX_W-1:0] slot,
                                input longint x, input longint y, input t_answer want);
        int       gap;
        t_verdict v;
        gap = 0;
        if (send_calm > 0)
            send_calm--;
        else if ($urandom_range(0, 24) == 0)
            send_calm = $urandom_range(10, 40);
        else
            gap = $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        vidx     <= slot;
        px       <= x[CW-1:0];
        py       <= y[CW-1:0];
        do @(posedge i_clk); while (in_stall !== 1'b0);
        sent_count++;
        if (f == picp_pkg::FUNC_LOAD) begin
            poly_x[slot] = x;
            poly_y[slot] = y;
        end else begin
            v.in_poly = (want == ANS_CALC) ? point_inside(x, y) : (want == ANS_IN);
            v.serial  = query_serial;
            query_serial++;
            inside_q.push_back(v);
        end
    endtask

    // Drop valid, wait for every pending result, then let trailing loads finish
    task automatic settle_block();
        in_valid <= 1'b0;
        while (inside_q.size() != 0) @(posedge i_clk);
        repeat (LOAD_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [picp_pkg::CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (cfg_ready !== 1'b1);
        poly_count = value;
        cfg_valid <= 1'b0;
    endtask

    // Load n vertices into slots 0..n-1: mostly rounded circles, sometimes noise
    task automatic load_polygon(input int n);
        int     style, i;
        longint cx, cy, rmax, rad, vx, vy;
        real    phi0, ang;
        style = $urandom_range(0, 9);
        cx = 0;
        cy = 0;
        rad = 32767;
        if (style >= 2) begin
            cx = longint'($urandom_range(0, 40000)) - 20000;
            cy = longint'($urandom_range(0, 40000)) - 20000;
            rmax = 32767 - (((cx < 0) ? -cx : cx) > ((cy < 0) ? -cy : cy) ?
                            ((cx < 0) ? -cx : cx) : ((cy < 0) ? -cy : cy));
            rad = (style < 5) ? longint'($urandom_range(1, 64))
                              : longint'($urandom_range(1, int'(rmax)));
        end
        phi0 = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
        for (i = 0; i < n; i++) begin
            if (style == 0) begin
                vx = rand_coord();
                vy = rand_coord();
            end else begin
                ang = phi0 + 2.0 * 3.14159265358979 * i / n;
                vx = clip_coord(cx + $rtoi(rad * $cos(ang)));
                vy = clip_coord(cy + $rtoi(rad * $sin(ang)));
            end
            send_request(picp_pkg::FUNC_LOAD, i[picp_pkg::IDX_W-1:0], vx, vy, ANS_CALC);
        end
    endtask

    // Pick a query point aimed at vertices, edges, fan diagonals and the interior
    task automatic pick_query(input int n, output longint qx, output longint qy);
        int a, b, c, t, wa, wb, wc;
        a = $urandom_range(0, n - 1);
        b = (a + 1) % n;
        c = $urandom_range(1, n - 1);
        case ($urandom_range(0, 9))
            0: begin
                qx = poly_x[a];
                qy = poly_y[a];
            end
            1: begin
                qx = (poly_x[a] + poly_x[b]) / 2;
                qy = (poly_y[a] + poly_y[b]) / 2;
            end
            2, 3: begin
                qx = poly_x[a] + int'($urandom_range(0, 4)) - 2;
                qy = poly_y[a] + int'($urandom_range(0, 4)) - 2;
            end
            4: begin
                // Points on the line through vertex 0 and a fan vertex
                t = $urandom_range(0, 3);
                case (t)
                    0: begin
                        qx = 2 * poly_x[0] - poly_x[c];
                        qy = 2 * poly_y[0] - poly_y[c];
                    end
                    1: begin
                        qx = (poly_x[0] + poly_x[c]) / 2;
                        qy = (poly_y[0] + poly_y[c]) / 2;
                    end
                    default: begin
                        qx = poly_x[0] + t * (poly_x[c] - poly_x[0]);
                        qy = poly_y[0] + t * (poly_y[c] - poly_y[0]);
                    end
                endcase
            end
            5, 6: begin
                wa = $urandom_range(1, 8);
                wb = $urandom_range(1, 8);
                wc = $urandom_range(1, 8);
                qx = (wa * poly_x[a] + wb * poly_x[b] + wc * poly_x[c]) / (wa + wb + wc);
                qy = (wa * poly_y[a] + wb * poly_y[b] + wc * poly_y[c]) / (wa + wb + wc);
            end
            7: begin
                qx = rand_coord();
                qy = rand_coord();
            end
            8: begin
                qx = poly_x[a] + int'($urandom_range(0, 1024)) - 512;
                qy = poly_y[a] + int'($urandom_range(0, 1024)) - 512;
            end
            default: begin
                qx = extreme_coord();
                qy = extreme_coord();
            end
        endcase
        qx = clip_coord(qx);
        qy = clip_coord(qy);
    endtask

    // Result side: random stalls, one long hold on request, compare in order
    initial begin : result_sink
        int       hold;
        int       calm;
        t_verdict head;
        calm = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = 0;
            if (hold_request) begin
                hold_request = 1'b0;
                hold = LONG_HOLD;
            end else if (calm > 0)
                calm--;
            else if ($urandom_range(0, 24) == 0)
                calm = $urandom_range(10, 40);
            else
                hold = $urandom_range(0, 4);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (out_valid !== 1'b1);
            if (inside_q.size() == 0) begin
                note_mismatch($sformatf("unexpected result: expected none, got inside_res=%b",
                                        inside_res));
            end else begin
                head = inside_q.pop_front();
                if (inside_res !== head.in_poly)
                    note_mismatch($sformatf("query %0d: expected inside_res=%b, got %b",
                                            head.serial, head.in_poly, inside_res));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[point_in_convex_polygon_core] ERROR");
        $finish;
    end

    initial begin : stimulus
        t_script_row                row;
        int                         k, phase, n, nq, r, start;
        logic [picp_pkg::CNT_W-1:0] count;
        longint                     qx, qy;

        // Directed rows: square at the coordinate extremes, then a small right triangle
        script_row(ROW_LOAD,  0, -32768, -32768, ANS_CALC);
        script_row(ROW_LOAD,  1,  32767, -32768, ANS_CALC);
        script_row(ROW_LOAD,  2,  32767,  32767, ANS_CALC);
        script_row(ROW_LOAD,  3, -32768,  32767, ANS_CALC);
        // Reset count of three: only the lower-right triangle is in use
        script_row(ROW_QUERY, 0, -30000,  30000, ANS_OUT);
        script_row(ROW_QUERY, 0,  32767, -32768, ANS_IN);
        script_row(ROW_CFG,   4,      0,      0, ANS_CALC);
        script_row(ROW_QUERY, 0, -30000,  30000, ANS_IN);
        script_row(ROW_QUERY, 0,      0,      0, ANS_IN);
        script_row(ROW_QUERY, 0, -32768,  32767, ANS_IN);
        script_row(ROW_QUERY, 0,      0,  32767, ANS_IN);
        script_row(ROW_QUERY, 0,     -1,     -1, ANS_IN);
        script_row(ROW_QUERY, 0,  12345, -20000, ANS_CALC);
        // Count below three clamps up to three
        script_row(ROW_CFG,   0,      0,      0, ANS_CALC);
        script_row(ROW_QUERY, 0, -30000,  30000, ANS_OUT);
        script_row(ROW_LOAD,  0,      0,      0, ANS_CALC);
        script_row(ROW_LOAD,  1,     10,      0, ANS_CALC);
        script_row(ROW_LOAD,  2,      0,     10, ANS_CALC);
        // Collinear points outside the segment box, on edges, and just beyond an edge
        script_row(ROW_QUERY, 0,     20,      0, ANS_OUT);
        script_row(ROW_QUERY, 0,     -5,      0, ANS_CALC);
        script_row(ROW_QUERY, 0,      5,      5, ANS_IN);
        script_row(ROW_QUERY, 0,      6,      6, ANS_OUT);
        script_row(ROW_QUERY, 0,      0,      5, ANS_IN);
        script_row(ROW_QUERY, 0,  32767,  32767, ANS_OUT);

        poly_count = picp_pkg::CNT_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (k = 0; k < script.size(); k++) begin
            row = script[k];
            if (row.kind == ROW_CFG) begin
                settle_block();
                write_count(row.arg);
            end else begin
                send_request((row.kind == ROW_QUERY) ? picp_pkg::FUNC_QUERY
                                                     : picp_pkg::FUNC_LOAD,
                             row.arg[picp_pkg::IDX_W-1:0], row.x, row.y, row.want);
            end
        end

        // Random phases: new count, fresh polygon, then queries mixed with stray loads
        start = sent_count;
        phase = 0;
        while (sent_count - start < RANDOM_ITEMS) begin
            settle_block();
            case (phase)
                0: count = 9'd256;
                1: count = 9'd511;
                2: count = 9'd0;
                default: begin
                    r = $urandom_range(0, 15);
                    if (r == 0)
                        count = (picp_pkg::CNT_W)'($urandom_range(0, 2));
                    else if (r == 1)
                        count = 9'd256;
                    else if (r == 2)
                        count = (picp_pkg::CNT_W)'($urandom_range(257, 511));
                    else if (r == 3)
                        count = 9'd3;
                    else
                        count = (picp_pkg::CNT_W)'($urandom_range(4, 48));
                end
            endcase
            write_count(count);
            n = used_vertices(count);
            load_polygon(n);
            if (phase == 3)
                hold_request = 1'b1;
            nq = $urandom_range(20, 60);
            repeat (nq) begin
                r = $urandom_range(0, 39);
                if (r < 4 && n < SLOTS) begin
                    send_request(picp_pkg::FUNC_LOAD,
                                 (picp_pkg::IDX_W)'($urandom_range(n, SLOTS - 1)),
                                 rand_coord(), rand_coord(), ANS_CALC);
                end else if (r == 4) begin
                    // Disturb a vertex that is in use
                    send_request(picp_pkg::FUNC_LOAD,
                                 (picp_pkg::IDX_W)'($urandom_range(0, n - 1)),
                                 rand_coord(), rand_coord(), ANS_CALC);
                end else begin
                    pick_query(n, qx, qy);
                    send_request(picp_pkg::FUNC_QUERY,
                                 (picp_pkg::IDX_W)'($urandom_range(0, SLOTS - 1)),
                                 qx, qy, ANS_CALC);
                end
            end
            phase++;
        end

        settle_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("[point_in_convex_polygon_core] OK");
        else
            $display("[point_in_convex_polygon_core] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/picp_pkg.sv
design/picp_orient.sv
design/point_in_convex_polygon_core.sv
design/picp_checker.sv
test/point_in_convex_polygon_core_tb.sv
